// ===== sv/ray_aabb_slab_intersect_core_macros.svh =====
// Assertion macros for the ray/box slab test core.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef RAY_AABB_SLAB_INTERSECT_CORE_MACROS_SVH
`define RAY_AABB_SLAB_INTERSECT_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define RASI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset
`define RASI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/rasi_pkg.sv =====
// Shared types and constants for the ray/box slab test core.
// No dependencies; used by the divider lane and the top level.
package rasi_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int SUM_W  = WORD_W + 1;       // corner width
    localparam int NUM_W  = WORD_W + 3;       // slab numerator width
    localparam int MAG_W  = NUM_W - 1;        // numerator magnitude width
    localparam int N_W    = MAG_W + FRAC_W;   // scaled dividend width
    localparam int QBITS  = WORD_W - 1;       // quotient bits below saturation
    localparam int DIST_W = WORD_W - 1;
    localparam int NAXES  = 3;
    // divider lane depth in registers: operand stage, setup stage, QBITS steps, result stage
    localparam int DIV_LAT = QBITS + 3;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [NUM_W-1:0]  t_num;
    typedef logic [DIST_W-1:0]        t_dist;

    localparam t_word T_INF  = t_word'(32'sh7FFF_FFFF);
    localparam t_word T_NINF = t_word'(-32'sh7FFF_FFFF);

    typedef struct packed {
        logic en;
    } t_div_ctl;

endpackage

// ===== sv/rasi_if.sv =====
// Valid/ready channel interfaces of the ray/box slab test core.
// No dependencies.
interface rasi_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] box_center_x;
    logic signed [31:0] box_center_y;
    logic signed [31:0] box_center_z;
    logic signed [31:0] box_half_x;
    logic signed [31:0] box_half_y;
    logic signed [31:0] box_half_z;
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [31:0] ray_origin_z;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;

    modport source (
        output valid, box_center_x, box_center_y, box_center_z,
               box_half_x, box_half_y, box_half_z,
               ray_origin_x, ray_origin_y, ray_origin_z,
               ray_dir_x, ray_dir_y, ray_dir_z,
        input  ready
    );
    modport sink (
        input  valid, box_center_x, box_center_y, box_center_z,
               box_half_x, box_half_y, box_half_z,
               ray_origin_x, ray_origin_y, ray_origin_z,
               ray_dir_x, ray_dir_y, ray_dir_z,
        output ready
    );
endinterface

interface rasi_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [30:0] distance;

    modport source (output valid, hit, distance, input ready);
    modport sink (input valid, hit, distance, output ready);
endinterface

// ===== sv/rasi_div.sv =====
// Pipelined slab-distance divider: (num * 2^16) / dir, truncated, saturated.
// Depends on rasi_pkg; one quotient bit per register stage.
module rasi_div (
    input  logic               i_clk,
    input  rasi_pkg::t_div_ctl i_ctl,
    input  rasi_pkg::t_num     i_num,
    input  rasi_pkg::t_word    i_dir,
    input  logic               i_lo_side,
    output rasi_pkg::t_word    o_t
);
    import rasi_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0]  mag_n;
        logic [WORD_W-1:0] mag_d;
        logic              neg;
        logic              dzero;
        logic              zpos;
    } t_div_op;

    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [QBITS-1:0]  low;
        logic [QBITS-1:0]  q;
        logic [WORD_W-1:0] d;
        logic              neg;
        logic              fixed;
        logic              pos;
    } t_div_st;

    t_div_op          r_a, n_a;
    t_div_st          r_st [0:QBITS];
    t_div_st          n_st [0:QBITS];
    t_word            r_t, n_t;
    logic [N_W-1:0]   w_nfull;

    // take magnitudes and the sign of the quotient
    always_comb begin
        n_a.mag_n = i_num[NUM_W-1] ? MAG_W'(-i_num) : MAG_W'(i_num);
        n_a.mag_d = i_dir[WORD_W-1] ? WORD_W'(-i_dir) : WORD_W'(i_dir);
        n_a.neg   = i_num[NUM_W-1] ^ i_dir[WORD_W-1];
        n_a.dzero = (i_dir == '0);
        // zero direction: lo side is +inf only past the slab, hi side -inf only past it
        n_a.zpos  = i_lo_side ? (i_num > 0) : (i_num >= 0);
    end

    assign w_nfull = {r_a.mag_n, {FRAC_W{1'b0}}};

    // detect saturation and load the partial remainder, then
    // run the restoring steps, one quotient bit per stage
    always_comb begin
        logic [WORD_W:0] trial;
        logic            ge;
        n_st[0].rem   = WORD_W'(w_nfull[N_W-1:QBITS]);
        n_st[0].low   = w_nfull[QBITS-1:0];
        n_st[0].q     = '0;
        n_st[0].d     = r_a.mag_d;
        n_st[0].neg   = r_a.neg;
        n_st[0].fixed = r_a.dzero || (WORD_W'(w_nfull[N_W-1:QBITS]) >= r_a.mag_d);
        n_st[0].pos   = r_a.dzero ? r_a.zpos : !r_a.neg;
        for (int k = 1; k <= QBITS; k++) begin
            trial     = {r_st[k-1].rem, r_st[k-1].low[QBITS-1]};
            ge        = (trial >= (WORD_W+1)'(r_st[k-1].d));
            n_st[k]   = r_st[k-1];
            n_st[k].rem = ge ? WORD_W'(trial - (WORD_W+1)'(r_st[k-1].d))
                             : WORD_W'(trial);
            n_st[k].low = {r_st[k-1].low[QBITS-2:0], 1'b0};
            n_st[k].q   = {r_st[k-1].q[QBITS-2:0], ge};
        end
    end

    // apply sign, saturation and the zero-direction rule
    always_comb begin
        if (r_st[QBITS].fixed) begin
            n_t = r_st[QBITS].pos ? T_INF : T_NINF;
        end else if (r_st[QBITS].neg) begin
            n_t = -t_word'({1'b0, r_st[QBITS].q});
        end else begin
            n_t = t_word'({1'b0, r_st[QBITS].q});
        end
    end

    // advance the whole lane together
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_a <= n_a;
            for (int k = 0; k <= QBITS; k++) begin
                r_st[k] <= n_st[k];
            end
            r_t <= n_t;
        end
    end

    assign o_t = r_t;

endmodule

// ===== sv/ray_aabb_slab_intersect_core.sv =====
// Ray versus axis-aligned box slab test, signed Q16.16, fully pipelined.
// Depends on rasi_pkg, rasi_if (rasi_in_if, rasi_out_if) and rasi_div.
//
//  port    dir  carries
//  i_in    in   box center, half extents, ray origin, direction (valid/ready)
//  o_out   out  hit flag and unsigned Q15.16 distance (valid/ready)
//
// One item enters per cycle unless the output stalls; the pipe is two operand
// stages, the six parallel bit-per-stage divider lanes, two reduce stages and
// the output register. The whole pipe advances when the output register is
// empty or taken, so a stall freezes every stage. Reset clears valid bits only.
`include "ray_aabb_slab_intersect_core_macros.svh"
module ray_aabb_slab_intersect_core (
    input logic i_clk,
    input logic i_rst_n,
    rasi_in_if.sink    i_in,
    rasi_out_if.source o_out
);
    import rasi_pkg::*;

    logic      w_en;
    t_div_ctl  w_ctl;

    t_word     w_c [NAXES];
    t_word     w_h [NAXES];
    t_word     w_o [NAXES];
    t_word     w_d [NAXES];

    logic      r_v1, r_v2, r_v3, r_v4, r_ov;
    logic      r_vd [0:DIV_LAT-1];
    t_sum      r_lo [NAXES];
    t_sum      r_hi [NAXES];
    t_word     r_o1 [NAXES];
    t_word     r_d1 [NAXES];
    t_num      r_nlo [NAXES];
    t_num      r_nhi [NAXES];
    t_word     r_d2 [NAXES];
    t_word     w_tlo [NAXES];
    t_word     w_thi [NAXES];
    t_word     r_mn [NAXES];
    t_word     r_mx [NAXES];
    t_word     r_near, r_far, n_near, n_far;
    logic      r_hit, n_hit;
    t_dist     r_dist, n_dist;

    assign w_en      = !r_ov || o_out.ready;
    assign w_ctl.en  = w_en;
    assign i_in.ready = w_en;

    assign w_c[0] = i_in.box_center_x;
    assign w_c[1] = i_in.box_center_y;
    assign w_c[2] = i_in.box_center_z;
    assign w_h[0] = i_in.box_half_x;
    assign w_h[1] = i_in.box_half_y;
    assign w_h[2] = i_in.box_half_z;
    assign w_o[0] = i_in.ray_origin_x;
    assign w_o[1] = i_in.ray_origin_y;
    assign w_o[2] = i_in.ray_origin_z;
    assign w_d[0] = i_in.ray_dir_x;
    assign w_d[1] = i_in.ray_dir_y;
    assign w_d[2] = i_in.ray_dir_z;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_v1    <= i_in.valid;
            r_v2    <= r_v1;
            r_vd[0] <= r_v2;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
            r_v3 <= r_vd[DIV_LAT-1];
            r_v4 <= r_v3;
            r_ov <= r_v4;
        end
    end

    // form box corners, then slab numerators
    always_ff @(posedge i_clk) begin
        t_sum hs;
        t_sum habs;
        if (w_en) begin
            for (int a = 0; a < NAXES; a++) begin
                hs       = SUM_W'(w_h[a]);
                habs     = hs[SUM_W-1] ? -hs : hs;
                r_lo[a]  <= SUM_W'(w_c[a]) - habs;
                r_hi[a]  <= SUM_W'(w_c[a]) + habs;
                r_o1[a]  <= w_o[a];
                r_d1[a]  <= w_d[a];
                r_nlo[a] <= NUM_W'(r_lo[a]) - NUM_W'(r_o1[a]);
                r_nhi[a] <= NUM_W'(r_hi[a]) - NUM_W'(r_o1[a]);
                r_d2[a]  <= r_d1[a];
            end
        end
    end

    // six divider lanes
    for (genvar a = 0; a < NAXES; a++) begin : g_axis
        rasi_div u_div_lo (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_num     (r_nlo[a]),
            .i_dir     (r_d2[a]),
            .i_lo_side (1'b1),
            .o_t       (w_tlo[a])
        );
        rasi_div u_div_hi (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_num     (r_nhi[a]),
            .i_dir     (r_d2[a]),
            .i_lo_side (1'b0),
            .o_t       (w_thi[a])
        );
    end

    // order each axis pair
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < NAXES; a++) begin
                r_mn[a] <= (w_tlo[a] < w_thi[a]) ? w_tlo[a] : w_thi[a];
                r_mx[a] <= (w_tlo[a] > w_thi[a]) ? w_tlo[a] : w_thi[a];
            end
        end
    end

    // reduce to entry and exit distances
    always_comb begin
        n_near = (r_mn[0] > r_mn[1]) ? r_mn[0] : r_mn[1];
        n_near = (r_mn[2] > n_near) ? r_mn[2] : n_near;
        n_far  = (r_mx[0] < r_mx[1]) ? r_mx[0] : r_mx[1];
        n_far  = (r_mx[2] < n_far) ? r_mx[2] : n_far;
    end

    // decide hit and pick the distance
    always_comb begin
        if (r_far < 0 || r_near > r_far) begin
            n_hit  = 1'b0;
            n_dist = '0;
        end else begin
            n_hit  = 1'b1;
            n_dist = (r_near < 0) ? r_far[DIST_W-1:0] : r_near[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_near <= n_near;
            r_far  <= n_far;
            r_hit  <= n_hit;
            r_dist <= n_dist;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.hit      = r_hit;
    assign o_out.distance = r_dist;

    `RASI_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, r_ov && !r_hit, r_dist == '0)
    `RASI_ASSERT_NOW(a_bounds, i_clk, i_rst_n, r_v4, (r_near >= T_NINF) && (r_far <= T_INF))
    `RASI_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(r_v4) && $stable(r_v3))

endmodule
